// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ICSP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ICSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/icsp_pkg.sv =====
// ----------------------------------------------------------------------------
// icsp_pkg
// Shared types, constants and character classes of the INI stream parser.
// ----------------------------------------------------------------------------
package icsp_pkg;

    localparam int SECTION_MAX   = 32;
    localparam int BLANK_RUN_MAX = 16;

    localparam int SEC_LEN_W = $clog2(SECTION_MAX + 1);
    localparam int SEC_IDX_W = $clog2(SECTION_MAX);
    localparam int PEND_W    = $clog2(BLANK_RUN_MAX + 2);
    localparam int CNT_MAX   = (SECTION_MAX > BLANK_RUN_MAX) ? SECTION_MAX : BLANK_RUN_MAX;
    localparam int CNT_W     = $clog2(CNT_MAX);
    localparam int LINE_W    = 17;

    localparam logic [LINE_W-1:0] LINE_TOP = {LINE_W{1'b1}};

    // Result kinds.
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;
    localparam logic [1:0] KIND_EOF   = 2'd3;

    // Report status codes.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_RBRACK   = 4'd1;
    localparam logic [3:0] ST_NO_EQUAL    = 4'd2;
    localparam logic [3:0] ST_UNEXPECTED  = 4'd3;
    localparam logic [3:0] ST_EARLY_EOF   = 4'd4;
    localparam logic [3:0] ST_NO_SECTION  = 4'd5;
    localparam logic [3:0] ST_NO_NAME     = 4'd6;
    localparam logic [3:0] ST_BAD_ESC     = 4'd7;
    localparam logic [3:0] ST_SEC_LONG    = 4'd8;
    localparam logic [3:0] ST_BLANK_LONG  = 4'd9;
    localparam logic [3:0] ST_ABORTED     = 4'd10;

    localparam logic [3:0] ERR_LIMIT_RESET = 4'd5;

    // Characters.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    typedef enum logic [3:0] {
        P_LINE, P_SKIP, P_SEC_OPEN, P_SEC_NAME, P_SEC_CLOSE, P_SEC_TAIL,
        P_NAME, P_NAME_END, P_EQ, P_UNQ, P_QUO
    } parse_phase_t;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_SEC, S_DOT, S_BLANK, S_TAIL
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_SEC, SEL_DOT, SEL_BLANK, SEL_TAIL
    } emit_sel_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] status;
    } tail_item_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        emit_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic has_sec;
        logic has_blank;
        logic has_tail;
        logic last;
        logic out_free;
    } dp_status_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER) || (b == CH_DASH);
    endfunction

    function automatic logic is_printable(input logic [7:0] b);
        return (b >= CH_PRINT_LO) && (b <= CH_PRINT_HI);
    endfunction

endpackage

// ===== design/icsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// icsp_ctrl
// Sequencer: accepts a word, then walks the result plan one item per cycle while the output register is free.
// ----------------------------------------------------------------------------
module icsp_ctrl import icsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = SEL_TAIL;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (status.has_sec) begin
                    state_next = S_SEC;
                end else if (status.has_blank) begin
                    state_next = S_BLANK;
                end else if (status.has_tail) begin
                    state_next = S_TAIL;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_SEC: begin
                cmd.sel  = SEL_SEC;
                cmd.emit = status.out_free;
                if (status.out_free && status.last) begin
                    state_next = S_DOT;
                end
            end
            S_DOT: begin
                cmd.sel  = SEL_DOT;
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    state_next = status.has_blank ? S_BLANK : S_TAIL;
                end
            end
            S_BLANK: begin
                cmd.sel  = SEL_BLANK;
                cmd.emit = status.out_free;
                if (status.out_free && status.last) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                cmd.sel  = SEL_TAIL;
                cmd.emit = status.out_free;
                if (status.out_free && status.last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/icsp_dpath.sv =====
// ----------------------------------------------------------------------------
// icsp_dpath
// Parser state, section store, result plan and the output register.
// ----------------------------------------------------------------------------
module icsp_dpath import icsp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  logic              in_end,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_value,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [1:0]        out_kind,
    output logic [7:0]        out_byte,
    output logic [3:0]        out_status,
    output logic [LINE_W-1:0] out_line,
    output logic              out_last
);

    // Parser state.
    parse_phase_t         phase_reg,  phase_next;
    logic [SEC_LEN_W-1:0] sec_len_reg, sec_len_next;
    logic [LINE_W-1:0]    line_reg,   line_next;
    logic [3:0]           err_reg,    err_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic                 kdot_reg,   kdot_next;
    logic                 klast_reg,  klast_next;
    logic [PEND_W-1:0]    pend_reg,   pend_next;
    logic                 vesc_reg,   vesc_next;
    logic                 vbad_reg,   vbad_next;
    logic                 abort_reg,  abort_next;
    logic [3:0]           limit_reg;

    logic [7:0] sec_mem [SECTION_MAX];
    logic [7:0] sec_rd_reg;

    // Result plan of the word in flight.
    logic                 plan_sec_reg;
    logic [SEC_LEN_W-1:0] plan_len_reg;
    logic [PEND_W-1:0]    plan_blank_reg;
    tail_item_t           tail_reg [3];
    logic [1:0]           tail_n_reg;
    logic [LINE_W-1:0]    line_out_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 m_valid_reg;
    logic [1:0]           kind_reg;
    logic [7:0]           byte_reg;
    logic [3:0]           stat_reg;
    logic [LINE_W-1:0]    oline_reg;
    logic                 last_reg;

    // Combinational parse results.
    logic                 sec_we;
    logic [SEC_IDX_W-1:0] sec_waddr;
    logic                 rep_sec;
    logic [PEND_W-1:0]    rep_blank;
    tail_item_t           tail_next [3];
    logic [1:0]           tail_n_next;

    // Returns {record_done, fail code} for closing the open phase.
    function automatic logic [4:0] close_code(input parse_phase_t p, input logic eof);
        logic [4:0] r;
        r = {1'b0, ST_OK};
        case (p)
            P_SEC_OPEN:              r = {1'b0, eof ? ST_EARLY_EOF : ST_UNEXPECTED};
            P_SEC_NAME, P_SEC_CLOSE: r = {1'b0, ST_NO_RBRACK};
            P_NAME, P_NAME_END:      r = {1'b0, ST_NO_EQUAL};
            P_EQ, P_UNQ:             r = {1'b1, ST_OK};
            P_QUO:                   r = {1'b0, eof ? ST_EARLY_EOF : ST_UNEXPECTED};
            default:                 r = {1'b0, ST_OK};
        endcase
        return r;
    endfunction

    always_comb begin
        logic       rec;
        logic [3:0] fcode;
        logic       okrep;
        logic       abort_emit;
        logic       eof_emit;
        logic       line_end;
        logic       byte_emit;
        logic [1:0] byte_kind;
        logic [7:0] byte_val;
        logic [4:0] cl;
        logic [1:0] tn;

        phase_next   = phase_reg;
        sec_len_next = sec_len_reg;
        line_next    = line_reg;
        err_next     = err_reg;
        prev_cr_next = prev_cr_reg;
        kdot_next    = kdot_reg;
        klast_next   = klast_reg;
        pend_next    = pend_reg;
        vesc_next    = vesc_reg;
        vbad_next    = vbad_reg;
        abort_next   = abort_reg;
        sec_we       = 1'b0;
        sec_waddr    = '0;
        rep_sec      = 1'b0;
        rep_blank    = '0;
        rec          = 1'b0;
        fcode        = ST_OK;
        okrep        = 1'b0;
        abort_emit   = 1'b0;
        eof_emit     = 1'b0;
        line_end     = 1'b0;
        byte_emit    = 1'b0;
        byte_kind    = KIND_KEY;
        byte_val     = in_byte;
        cl           = '0;
        tn           = '0;

        if (in_end) begin
            if (!abort_reg) begin
                cl    = close_code(phase_reg, 1'b1);
                rec   = cl[4];
                fcode = cl[3:0];
            end
            eof_emit = 1'b1;
        end else if (!abort_reg) begin
            if (in_byte == CH_LF && prev_cr_reg) begin
                // Second half of a CR LF pair.
                prev_cr_next = 1'b0;
            end else begin
                prev_cr_next = (in_byte == CH_CR);
                if (in_byte == CH_LF || in_byte == CH_CR) begin
                    cl       = close_code(phase_reg, 1'b0);
                    rec      = cl[4];
                    fcode    = cl[3:0];
                    line_end = 1'b1;
                end else begin
                    case (phase_reg)
                        P_LINE: begin
                            if (is_blank(in_byte)) begin
                            end else if (in_byte == CH_LBRACK) begin
                                phase_next = P_SEC_OPEN;
                            end else if (is_name_char(in_byte)) begin
                                rep_sec    = (sec_len_reg != '0);
                                kdot_next  = (sec_len_reg != '0);
                                klast_next = 1'b0;
                                byte_emit  = 1'b1;
                                phase_next = P_NAME;
                            end else if (in_byte == CH_SEMI || in_byte == CH_HASH) begin
                                phase_next = P_SKIP;
                            end else begin
                                fcode = ST_UNEXPECTED;
                            end
                        end
                        P_SEC_OPEN: begin
                            if (is_blank(in_byte)) begin
                            end else if (is_name_char(in_byte)) begin
                                sec_we       = 1'b1;
                                sec_len_next = SEC_LEN_W'(1);
                                phase_next   = P_SEC_NAME;
                            end else begin
                                fcode = ST_UNEXPECTED;
                            end
                        end
                        P_SEC_NAME: begin
                            if (is_name_char(in_byte) || in_byte == CH_DOT) begin
                                if (sec_len_reg >= SEC_LEN_W'(SECTION_MAX)) begin
                                    sec_len_next = '0;
                                    fcode        = ST_SEC_LONG;
                                end else begin
                                    sec_we       = 1'b1;
                                    sec_waddr    = sec_len_reg[SEC_IDX_W-1:0];
                                    sec_len_next = sec_len_reg + SEC_LEN_W'(1);
                                end
                            end else if (is_blank(in_byte)) begin
                                phase_next = P_SEC_CLOSE;
                            end else if (in_byte == CH_RBRACK) begin
                                phase_next = P_SEC_TAIL;
                            end else begin
                                fcode = ST_NO_RBRACK;
                            end
                        end
                        P_SEC_CLOSE: begin
                            if (is_blank(in_byte)) begin
                            end else if (in_byte == CH_RBRACK) begin
                                phase_next = P_SEC_TAIL;
                            end else begin
                                fcode = ST_NO_RBRACK;
                            end
                        end
                        P_SEC_TAIL: begin
                            if (is_blank(in_byte)) begin
                            end else if (in_byte == CH_SEMI || in_byte == CH_HASH) begin
                                phase_next = P_SKIP;
                            end else begin
                                fcode = ST_UNEXPECTED;
                            end
                        end
                        P_NAME: begin
                            if (is_name_char(in_byte) || in_byte == CH_DOT) begin
                                byte_emit = 1'b1;
                                if (in_byte == CH_DOT) begin
                                    kdot_next  = 1'b1;
                                    klast_next = 1'b1;
                                end else begin
                                    klast_next = 1'b0;
                                end
                            end else if (is_blank(in_byte)) begin
                                phase_next = P_NAME_END;
                            end else if (in_byte == CH_EQUAL) begin
                                vesc_next  = 1'b0;
                                vbad_next  = 1'b0;
                                pend_next  = '0;
                                phase_next = P_EQ;
                            end else begin
                                fcode = ST_NO_EQUAL;
                            end
                        end
                        P_NAME_END: begin
                            if (is_blank(in_byte)) begin
                            end else if (in_byte == CH_EQUAL) begin
                                vesc_next  = 1'b0;
                                vbad_next  = 1'b0;
                                pend_next  = '0;
                                phase_next = P_EQ;
                            end else begin
                                fcode = ST_NO_EQUAL;
                            end
                        end
                        P_EQ: begin
                            if (is_blank(in_byte)) begin
                            end else if (in_byte == CH_QUOTE) begin
                                phase_next = P_QUO;
                            end else if (is_printable(in_byte) && in_byte != CH_SEMI &&
                                         in_byte != CH_HASH) begin
                                byte_emit  = 1'b1;
                                byte_kind  = KIND_VALUE;
                                phase_next = P_UNQ;
                            end else begin
                                rec = 1'b1;
                            end
                        end
                        P_UNQ: begin
                            if (in_byte == CH_SPACE) begin
                                pend_next = pend_reg + PEND_W'(1);
                                if (pend_next > PEND_W'(BLANK_RUN_MAX)) begin
                                    fcode = ST_BLANK_LONG;
                                end
                            end else if (is_printable(in_byte) && in_byte != CH_SEMI &&
                                         in_byte != CH_HASH) begin
                                // Held-back blanks are real once a later byte shows up.
                                rep_blank = pend_reg;
                                pend_next = '0;
                                byte_emit = 1'b1;
                                byte_kind = KIND_VALUE;
                            end else begin
                                rec = 1'b1;
                            end
                        end
                        P_QUO: begin
                            if (vesc_reg) begin
                                vesc_next = 1'b0;
                                if (!is_printable(in_byte)) begin
                                    fcode = ST_UNEXPECTED;
                                end else if (in_byte == CH_BSLASH || in_byte == CH_QUOTE) begin
                                    byte_emit = !vbad_reg;
                                end else if (in_byte == CH_LOW_N) begin
                                    byte_emit = !vbad_reg;
                                    byte_val  = CH_LF;
                                end else if (in_byte == CH_LOW_R) begin
                                    byte_emit = !vbad_reg;
                                    byte_val  = CH_CR;
                                end else if (in_byte == CH_LOW_T) begin
                                    byte_emit = !vbad_reg;
                                    byte_val  = CH_TAB;
                                end else begin
                                    vbad_next = 1'b1;
                                end
                                byte_kind = KIND_VALUE;
                            end else if (in_byte == CH_QUOTE) begin
                                rec = 1'b1;
                            end else if (in_byte == CH_BSLASH) begin
                                vesc_next = 1'b1;
                            end else if (is_printable(in_byte)) begin
                                byte_emit = !vbad_reg;
                                byte_kind = KIND_VALUE;
                            end else begin
                                fcode = ST_UNEXPECTED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        // Record check: key split first, then escape errors.
        if (rec) begin
            if (!kdot_reg) begin
                fcode = ST_NO_SECTION;
            end else if (klast_reg) begin
                fcode = ST_NO_NAME;
            end else if (vbad_reg) begin
                fcode = ST_BAD_ESC;
            end else begin
                okrep = 1'b1;
            end
        end

        if (fcode != ST_OK) begin
            err_next = (err_reg == 4'hF) ? err_reg : err_reg + 4'd1;
            if (err_next >= limit_reg) begin
                abort_emit = 1'b1;
                abort_next = 1'b1;
            end
            phase_next = P_SKIP;
        end
        if (okrep) begin
            phase_next = P_SKIP;
        end
        if (line_end) begin
            phase_next = P_LINE;
            if (line_reg != LINE_TOP) begin
                line_next = line_reg + LINE_W'(1);
            end
        end

        for (int i = 0; i < 3; i++) begin
            tail_next[i] = '0;
        end
        if (byte_emit) begin
            tail_next[tn] = '{kind: byte_kind, data: byte_val, status: ST_OK};
            tn = tn + 2'd1;
        end
        if (okrep || fcode != ST_OK) begin
            tail_next[tn] = '{kind: KIND_LINE, data: 8'd0, status: fcode};
            tn = tn + 2'd1;
        end
        if (abort_emit) begin
            tail_next[tn] = '{kind: KIND_LINE, data: 8'd0, status: ST_ABORTED};
            tn = tn + 2'd1;
        end
        if (eof_emit) begin
            tail_next[tn] = '{kind: KIND_EOF, data: 8'd0,
                              status: abort_next ? ST_ABORTED : ST_OK};
            tn = tn + 2'd1;
        end
        tail_n_next = tn;

        if (in_end) begin
            phase_next   = P_LINE;
            sec_len_next = '0;
            line_next    = LINE_W'(1);
            err_next     = '0;
            prev_cr_next = 1'b0;
            kdot_next    = 1'b0;
            klast_next   = 1'b0;
            pend_next    = '0;
            vesc_next    = 1'b0;
            vbad_next    = 1'b0;
            abort_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= P_LINE;
            sec_len_reg <= '0;
            line_reg    <= LINE_W'(1);
            err_reg     <= '0;
            prev_cr_reg <= 1'b0;
            kdot_reg    <= 1'b0;
            klast_reg   <= 1'b0;
            pend_reg    <= '0;
            vesc_reg    <= 1'b0;
            vbad_reg    <= 1'b0;
            abort_reg   <= 1'b0;
            limit_reg   <= ERR_LIMIT_RESET;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_value;
            end
            if (cmd.load) begin
                phase_reg   <= phase_next;
                sec_len_reg <= sec_len_next;
                line_reg    <= line_next;
                err_reg     <= err_next;
                prev_cr_reg <= prev_cr_next;
                kdot_reg    <= kdot_next;
                klast_reg   <= klast_next;
                pend_reg    <= pend_next;
                vesc_reg    <= vesc_next;
                vbad_reg    <= vbad_next;
                abort_reg   <= abort_next;
            end
        end
    end

    // The read address is taken from the next counter value, so the byte of the
    // current position is always waiting in the read register.
    always_ff @(posedge aclk) begin
        if (cmd.load && sec_we) begin
            sec_mem[sec_waddr] <= in_byte;
        end
        sec_rd_reg <= sec_mem[cnt_next[SEC_IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            plan_sec_reg   <= rep_sec;
            plan_len_reg   <= sec_len_reg;
            plan_blank_reg <= rep_blank;
            tail_reg       <= tail_next;
            tail_n_reg     <= tail_n_next;
            line_out_reg   <= line_reg;
        end
    end

    // Position within the current part of the plan.
    logic last_in_sel;
    always_comb begin
        case (cmd.sel)
            SEL_SEC:   last_in_sel = (SEC_LEN_W'(cnt_reg) + SEC_LEN_W'(1)) == plan_len_reg;
            SEL_DOT:   last_in_sel = 1'b1;
            SEL_BLANK: last_in_sel = (PEND_W'(cnt_reg) + PEND_W'(1)) == plan_blank_reg;
            SEL_TAIL:  last_in_sel = (cnt_reg[1:0] + 2'd1) == tail_n_reg;
            default:   last_in_sel = 1'b1;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.load) begin
            cnt_next = '0;
        end else if (cmd.emit) begin
            cnt_next = last_in_sel ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    tail_item_t item;
    always_comb begin
        case (cmd.sel)
            SEL_SEC:   item = '{kind: KIND_KEY, data: sec_rd_reg, status: ST_OK};
            SEL_DOT:   item = '{kind: KIND_KEY, data: CH_DOT, status: ST_OK};
            SEL_BLANK: item = '{kind: KIND_VALUE, data: CH_SPACE, status: ST_OK};
            SEL_TAIL:  item = tail_reg[cnt_reg[1:0]];
            default:   item = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg  <= item.kind;
            byte_reg  <= item.data;
            stat_reg  <= item.status;
            oline_reg <= line_out_reg;
            last_reg  <= (cmd.sel == SEL_TAIL) && last_in_sel;
        end
    end

    assign status.has_sec   = plan_sec_reg;
    assign status.has_blank = (plan_blank_reg != '0);
    assign status.has_tail  = (tail_n_reg != '0);
    assign status.last      = last_in_sel;
    assign status.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign out_kind   = kind_reg;
    assign out_byte   = byte_reg;
    assign out_status = stat_reg;
    assign out_line   = oline_reg;
    assign out_last   = last_reg;

endmodule

// ===== design/ini_config_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ini_config_stream_parser
// Streaming INI text parser: bytes in, key/value bytes and line reports out.
// ----------------------------------------------------------------------------
// One text byte (or an end-of-file marker) is taken per input word. The
// parser takes the word, then looks at its plan in a start state, then
// sends one result word per cycle while the output register is free. A
// word causes up to 34 results when the stored section name is replayed in
// front of a key. Results come from a single output register, and a word is
// only taken once all results of the previous word have been loaded into
// that register.
module ini_config_stream_parser import icsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic [0:0]  s_tuser,   // [0] is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [11:8] status_code, [28:12] line_number
    output logic [1:0]  m_tuser,   // [1:0] item_kind
    output logic        m_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // error_limit
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic [7:0]        out_byte;
    logic [3:0]        out_status;
    logic [LINE_W-1:0] out_line;

    assign cfg_ready = 1'b1;

    icsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    icsp_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (s_tdata),
        .in_end     (s_tuser[0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_value  (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_kind   (m_tuser),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_line   (out_line),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'b000, out_line, out_status, out_byte};

endmodule

// ===== design/icsp_checker.sv =====
// ----------------------------------------------------------------------------
// icsp_checker
// Port-level checks on the result stream of the INI stream parser.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icsp_checker import icsp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `ICSP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result word changed")

    // An end-of-file report always closes the run of its word.
    `ICSP_ASSERT_SAME(a_eof_last, aclk, aresetn, m_tvalid && m_tuser == KIND_EOF,
        m_tlast && (m_tdata[11:8] == ST_OK || m_tdata[11:8] == ST_ABORTED),
        "bad end-of-file report")

    // Key and value bytes carry no status.
    `ICSP_ASSERT_SAME(a_byte_status, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_KEY || m_tuser == KIND_VALUE),
        m_tdata[11:8] == ST_OK, "data byte with status")

    // Line numbers start at one.
    `ICSP_ASSERT_SAME(a_line_nonzero, aclk, aresetn, m_tvalid,
        m_tdata[28:12] != 17'd0, "line number zero")

endmodule

bind ini_config_stream_parser icsp_checker u_icsp_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the INI stream parser: a directed table, then
// random INI text. Every result word is checked against the table or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
    import icsp_pkg::*;

    localparam int MAX_OUT     = (SECTION_MAX + 2 > BLANK_RUN_MAX + 1) ?
                                 SECTION_MAX + 2 : BLANK_RUN_MAX + 1;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [3:0]  status;
        logic [16:0] line;
        logic        last;
    } report_t;

    typedef struct {
        logic [7:0] b;
        bit         eof;
        bit         typed;
        logic [1:0] kind;
        logic [3:0] status;
        int         line;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    ini_config_stream_parser dut (.*);

    // Model state.
    parse_phase_t ph;
    logic [7:0]   sec_name [SECTION_MAX];
    int           sec_len, line_no, errs, pend, lim;
    bit           prev_cr, key_dot, key_lastdot, esc, badesc, halted;
    report_t      step_out[$];
    report_t      expected_reports[$];

    bit quiet;
    int fails = 0;
    int idle_cycles = 0;
    int r_stall;

    function automatic bit blank_ch(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic bit name_ch(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               (b >= "0" && b <= "9") || b == CH_UNDER || b == CH_DASH;
    endfunction

    function automatic bit print_ch(logic [7:0] b);
        return b >= CH_PRINT_LO && b <= CH_PRINT_HI;
    endfunction

    function automatic void put(logic [1:0] k, logic [7:0] d, logic [3:0] s);
        if (step_out.size() < MAX_OUT)
            step_out.push_back('{k, d, s, line_no[16:0], 1'b0});
    endfunction

    function automatic void clear_parser();
        ph = P_LINE;
        foreach (sec_name[i]) sec_name[i] = 8'h00;
        sec_len = 0; line_no = 1; errs = 0; prev_cr = 0;
        key_dot = 0; key_lastdot = 0; pend = 0; esc = 0; badesc = 0; halted = 0;
    endfunction

    function automatic void report_error(logic [3:0] code);
        put(KIND_LINE, 8'h00, code);
        if (errs < 15) errs++;
        if (errs >= lim) begin
            put(KIND_LINE, 8'h00, ST_ABORTED);
            halted = 1;
        end
        ph = P_SKIP;
    endfunction

    function automatic void finish_record();
        if (!key_dot) report_error(ST_NO_SECTION);
        else if (key_lastdot) report_error(ST_NO_NAME);
        else if (badesc) report_error(ST_BAD_ESC);
        else put(KIND_LINE, 8'h00, ST_OK);
        ph = P_SKIP;
    endfunction

    function automatic void key_char(logic [7:0] b);
        put(KIND_KEY, b, ST_OK);
        key_lastdot = (b == CH_DOT);
        if (b == CH_DOT) key_dot = 1;
    endfunction

    function automatic void close_line(bit at_eof);
        case (ph)
            P_SEC_OPEN, P_QUO: report_error(at_eof ? ST_EARLY_EOF : ST_UNEXPECTED);
            P_SEC_NAME, P_SEC_CLOSE: report_error(ST_NO_RBRACK);
            P_NAME, P_NAME_END: report_error(ST_NO_EQUAL);
            P_EQ, P_UNQ: finish_record();
            default: ;
        endcase
    endfunction

    function automatic void open_value();
        esc = 0; badesc = 0; pend = 0; ph = P_EQ;
    endfunction

    function automatic void quoted_char(logic [7:0] b);
        logic [7:0] d;
        if (esc) begin
            esc = 0;
            if (!print_ch(b)) begin
                report_error(ST_UNEXPECTED);
                return;
            end
            if (b == CH_BSLASH || b == CH_QUOTE) d = b;
            else if (b == CH_LOW_N) d = CH_LF;
            else if (b == CH_LOW_R) d = CH_CR;
            else if (b == CH_LOW_T) d = CH_TAB;
            else begin
                badesc = 1;
                return;
            end
            if (!badesc) put(KIND_VALUE, d, ST_OK);
        end else if (b == CH_QUOTE) finish_record();
        else if (b == CH_BSLASH) esc = 1;
        else if (print_ch(b)) begin
            if (!badesc) put(KIND_VALUE, b, ST_OK);
        end else report_error(ST_UNEXPECTED);
    endfunction

    function automatic void text_char(logic [7:0] b);
        case (ph)
            P_LINE: begin
                if (blank_ch(b)) ;
                else if (b == CH_LBRACK) ph = P_SEC_OPEN;
                else if (name_ch(b)) begin
                    key_dot = sec_len != 0;
                    key_lastdot = 0;
                    for (int i = 0; i < sec_len; i++) put(KIND_KEY, sec_name[i], ST_OK);
                    if (sec_len != 0) put(KIND_KEY, CH_DOT, ST_OK);
                    key_char(b);
                    ph = P_NAME;
                end else if (b == CH_SEMI || b == CH_HASH) ph = P_SKIP;
                else report_error(ST_UNEXPECTED);
            end
            P_SEC_OPEN: begin
                if (blank_ch(b)) ;
                else if (name_ch(b)) begin
                    sec_name[0] = b; sec_len = 1; ph = P_SEC_NAME;
                end else report_error(ST_UNEXPECTED);
            end
            P_SEC_NAME: begin
                if (name_ch(b) || b == CH_DOT) begin
                    if (sec_len >= SECTION_MAX) begin
                        sec_len = 0;
                        report_error(ST_SEC_LONG);
                    end else begin
                        sec_name[sec_len] = b;
                        sec_len++;
                    end
                end else if (blank_ch(b)) ph = P_SEC_CLOSE;
                else if (b == CH_RBRACK) ph = P_SEC_TAIL;
                else report_error(ST_NO_RBRACK);
            end
            P_SEC_CLOSE: begin
                if (blank_ch(b)) ;
                else if (b == CH_RBRACK) ph = P_SEC_TAIL;
                else report_error(ST_NO_RBRACK);
            end
            P_SEC_TAIL: begin
                if (blank_ch(b)) ;
                else if (b == CH_SEMI || b == CH_HASH) ph = P_SKIP;
                else report_error(ST_UNEXPECTED);
            end
            P_NAME: begin
                if (name_ch(b) || b == CH_DOT) key_char(b);
                else if (blank_ch(b)) ph = P_NAME_END;
                else if (b == CH_EQUAL) open_value();
                else report_error(ST_NO_EQUAL);
            end
            P_NAME_END: begin
                if (blank_ch(b)) ;
                else if (b == CH_EQUAL) open_value();
                else report_error(ST_NO_EQUAL);
            end
            P_EQ: begin
                if (blank_ch(b)) ;
                else if (b == CH_QUOTE) ph = P_QUO;
                else if (print_ch(b) && b != CH_SEMI && b != CH_HASH) begin
                    put(KIND_VALUE, b, ST_OK);
                    ph = P_UNQ;
                end else finish_record();
            end
            P_UNQ: begin
                if (b == CH_SPACE) begin
                    pend++;
                    if (pend > BLANK_RUN_MAX) report_error(ST_BLANK_LONG);
                end else if (print_ch(b) && b != CH_SEMI && b != CH_HASH) begin
                    for (int i = 0; i < pend; i++) put(KIND_VALUE, CH_SPACE, ST_OK);
                    pend = 0;
                    put(KIND_VALUE, b, ST_OK);
                end else finish_record();
            end
            P_QUO: quoted_char(b);
            default: ;
        endcase
    endfunction

    // Works out the reports that one accepted word causes.
    function automatic void parse_word(logic [7:0] b, bit eof);
        step_out.delete();
        if (eof) begin
            if (!halted) close_line(1);
            put(KIND_EOF, 8'h00, halted ? ST_ABORTED : ST_OK);
            clear_parser();
        end else if (!halted) begin
            if (b == CH_LF && prev_cr) prev_cr = 0;
            else begin
                prev_cr = (b == CH_CR);
                if (b == CH_LF || b == CH_CR) begin
                    close_line(0);
                    if (line_no < 131071) line_no++;
                    ph = P_LINE;
                end else text_char(b);
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
    endfunction

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Result side: random stall bursts, none in the last register setting or the closing phase.
    initial begin
        m_tready = 0;
        r_stall = 0;
        forever begin
            @(negedge aclk);
            if (!quiet && r_stall > 0) begin
                r_stall--;
                m_tready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                r_stall = $urandom_range(0, 9);
                m_tready <= 0;
            end else m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        report_t got, want;
        bit      moved;
        if (aresetn) begin
            moved = (s_tvalid && s_tready) || (cfg_valid && cfg_ready) ||
                    (m_tvalid && m_tready);
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[28:12], m_tlast};
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %p", $time, got);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.kind != want.kind || got.data != want.data ||
                        got.status != want.status || got.line != want.line ||
                        got.last != want.last) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        fails++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the handshake.
    task automatic send_word(logic [7:0] b, bit eof, bit typed = 0,
                             logic [1:0] k = 0, logic [3:0] st = 0, int ln = 1);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tuser  <= eof;
        do @(posedge aclk); while (!s_tready);
        parse_word(b, eof);
        if (typed) expected_reports.push_back('{k, 8'h00, st, ln[16:0], 1'b1});
        else foreach (step_out[i]) expected_reports.push_back(step_out[i]);
        @(negedge aclk);
    endtask

    task automatic write_limit(logic [3:0] v);
        s_tvalid <= 0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        lim = v;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic logic [7:0] rand_name_ch();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range("a", "z"));
            1: return 8'($urandom_range("A", "Z"));
            2: return 8'($urandom_range("0", "9"));
            3: return CH_UNDER;
            default: return CH_DASH;
        endcase
    endfunction

    // Appends one random line of INI text (plus its line end and, at times, an end-of-file word) to the queue.
    function automatic void make_line(ref logic [8:0] txt[$]);
        int n;
        case ($urandom_range(0, 9))
            0, 1: begin
                txt.push_back({1'b0, CH_LBRACK});
                if ($urandom_range(0, 3) == 0) txt.push_back({1'b0, CH_SPACE});
                n = ($urandom_range(0, 12) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    txt.push_back({1'b0, ($urandom_range(0, 6) == 0) ? CH_DOT : rand_name_ch()});
                if ($urandom_range(0, 7) != 0) txt.push_back({1'b0, CH_RBRACK});
                if ($urandom_range(0, 4) == 0) txt.push_back({1'b0, CH_SEMI});
            end
            2, 3, 4, 5, 6: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    txt.push_back({1'b0, ($urandom_range(0, 7) == 0) ? CH_DOT : rand_name_ch()});
                if ($urandom_range(0, 2) == 0) txt.push_back({1'b0, CH_SPACE});
                if ($urandom_range(0, 9) != 0) txt.push_back({1'b0, CH_EQUAL});
                if ($urandom_range(0, 2) == 0) txt.push_back({1'b0, CH_TAB});
                if ($urandom_range(0, 1) == 0) begin
                    txt.push_back({1'b0, CH_QUOTE});
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            txt.push_back({1'b0, CH_BSLASH});
                            case ($urandom_range(0, 6))
                                0: txt.push_back({1'b0, CH_BSLASH});
                                1: txt.push_back({1'b0, CH_QUOTE});
                                2: txt.push_back({1'b0, CH_LOW_N});
                                3: txt.push_back({1'b0, CH_LOW_R});
                                4: txt.push_back({1'b0, CH_LOW_T});
                                5: txt.push_back({1'b0, 8'($urandom_range(0, 255))});
                                default: txt.push_back({1'b0, 8'($urandom_range(32, 126))});
                            endcase
                        end else txt.push_back({1'b0, 8'($urandom_range(32, 126))});
                    end
                    if ($urandom_range(0, 7) != 0) txt.push_back({1'b0, CH_QUOTE});
                end else begin
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 15) == 0)
                            repeat ($urandom_range(14, 19)) txt.push_back({1'b0, CH_SPACE});
                        else if ($urandom_range(0, 3) == 0) txt.push_back({1'b0, CH_SPACE});
                        else txt.push_back({1'b0, 8'($urandom_range(32, 126))});
                    end
                end
            end
            7: txt.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_SEMI : CH_HASH});
            8: ;
            default: repeat ($urandom_range(1, 3)) txt.push_back({1'b0, 8'($urandom_range(0, 255))});
        endcase
        case ($urandom_range(0, 2))
            0: txt.push_back({1'b0, CH_LF});
            1: txt.push_back({1'b0, CH_CR});
            default: begin
                txt.push_back({1'b0, CH_CR});
                txt.push_back({1'b0, CH_LF});
            end
        endcase
        if ($urandom_range(0, 9) == 0) txt.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    row_t dir_rows[$];
    logic [3:0] limits[4] = '{4'd1, 4'd15, 4'd3, ERR_LIMIT_RESET};

    initial begin
        logic [8:0] txt[$];
        string s;
        int sent;
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        cfg_valid = 0; cfg_data = 0;
        quiet = 0;
        lim = ERR_LIMIT_RESET;
        clear_parser();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed part: reset values, extremes of the byte, error and OK reports.
        dir_rows.push_back('{8'h00, 1, 1, KIND_EOF, ST_OK, 1});
        dir_rows.push_back('{8'h00, 0, 1, KIND_LINE, ST_UNEXPECTED, 1});
        dir_rows.push_back('{CH_LF, 0, 0, 0, 0, 0});
        dir_rows.push_back('{8'hFF, 0, 1, KIND_LINE, ST_UNEXPECTED, 2});
        dir_rows.push_back('{CH_CR, 0, 0, 0, 0, 0});
        s = "[s]\nk=\n.=\"a\\q\"\n";
        foreach (s[i]) dir_rows.push_back('{8'(s[i]), 0, 0, 0, 0, 0});
        dir_rows.push_back('{8'h00, 1, 0, 0, 0, 0});
        foreach (dir_rows[i])
            send_word(dir_rows[i].b, dir_rows[i].eof, dir_rows[i].typed,
                      dir_rows[i].kind, dir_rows[i].status, dir_rows[i].line);

        // Random part in four register settings; the last one runs without idling.
        sent = 0;
        for (int p = 0; p < 4; p++) begin
            write_limit(limits[p]);
            quiet = (p == 3);
            while (sent < (p + 1) * 100) begin
                if (txt.size() == 0) make_line(txt);
                send_word(txt[0][7:0], txt[0][8]);
                void'(txt.pop_front());
                sent++;
            end
            txt.delete();
            send_word(8'h00, 1);
        end
        s_tvalid <= 0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (fails == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
